[rtl/dual_grid_autotile_mask_macros.svh]
// assertion macros used by the checker file
`ifndef DUAL_GRID_AUTOTILE_MASK_MACROS_SVH
`define DUAL_GRID_AUTOTILE_MASK_MACROS_SVH

// property checked on every edge outside reset
`define DGAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DGAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dgat_pkg.sv]
// shared constants, types and tile tables for the dual grid autotile block
package dgat_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned CoordW    = 7;
  localparam int unsigned ColIdxW   = $clog2(MaxWidth);
  localparam int unsigned RowIdxW   = $clog2(MaxHeight);

  localparam logic [CoordW-1:0] MapWidthRst  = 7'd64;
  localparam logic [CoordW-1:0] MapHeightRst = 7'd64;

  typedef logic [CoordW-1:0]   coord_t;
  typedef logic [ColIdxW-1:0]  col_idx_t;
  typedef logic [RowIdxW-1:0]  row_idx_t;
  typedef logic [MaxWidth-1:0] row_word_t;

  typedef enum logic [1:0] {
    ActSet   = 2'd0,
    ActClear = 2'd1,
    ActQuery = 2'd2
  } action_e;

  typedef enum logic {
    CfgMapWidth  = 1'b0,
    CfgMapHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KindEmpty  = 3'd0,
    KindFull   = 3'd1,
    KindCorner = 3'd2,
    KindEdge   = 3'd3,
    KindNotch  = 3'd4,
    KindDnotch = 3'd5
  } tile_kind_e;

  typedef struct packed {
    logic      rd_en;
    row_idx_t  rd_addr;
    logic      wr_en;
    row_idx_t  wr_addr;
    row_word_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic       in_range;
    logic [3:0] mask;
    tile_kind_e kind;
    logic [1:0] turns;
  } result_t;

  function automatic tile_kind_e kind_of_mask(input logic [3:0] m);
    tile_kind_e k;
    case (m) inside
      4'd0:                      k = KindEmpty;
      4'd1, 4'd2, 4'd4, 4'd8:    k = KindCorner;
      4'd3, 4'd5, 4'd10, 4'd12:  k = KindEdge;
      4'd6, 4'd9:                k = KindDnotch;
      4'd7, 4'd11, 4'd13, 4'd14: k = KindNotch;
      default:                   k = KindFull;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] turns_of_mask(input logic [3:0] m);
    logic [1:0] t;
    case (m) inside
      4'd1, 4'd6, 4'd10, 4'd11: t = 2'd1;
      4'd2, 4'd12, 4'd14:       t = 2'd2;
      4'd5, 4'd8, 4'd13:        t = 2'd3;
      default:                  t = 2'd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/dual_grid_autotile_mask.sv]
// top level of the dual grid autotile mask block
// An item is taken when start is high and busy is low; its result appears
// on the result ports for a single cycle with result_valid_o high, and the
// receiver cannot stall it. A query inside the map keeps busy high through
// StRdA, StRdB and StRdC and a set or clear inside the map through StRdA and
// StRdB, since each row of the bitmap comes through one registered read port
// of the row memory: a query reads the row above and the row of the visual
// corner, and a set or clear reads its row and writes it back. An item outside
// the map or with an unused action leaves busy low and its result follows the
// next cycle, so the next item may be started at once. The bitmap needs no
// clearing pass: per-row valid bits read as empty until a row is first written.
// The configuration port is always ready and should only be written while idle.
module dual_grid_autotile_mask (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  dgat_pkg::coord_t   col_i,
  input  dgat_pkg::coord_t   row_i,
  output logic               result_valid_o,
  output logic               in_range_o,
  output logic [3:0]         mask_o,
  output logic [2:0]         tile_kind_o,
  output logic [1:0]         quarter_turns_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  dgat_pkg::cfg_reg_e cfg_index_i,
  input  dgat_pkg::coord_t   cfg_data_i
);
  import dgat_pkg::*;

  coord_t    map_width_q;
  coord_t    map_height_q;
  coord_t    width_eff;
  coord_t    height_eff;
  mem_req_t  mem_req;
  row_word_t mem_rdata;
  result_t   result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MapWidthRst;
      map_height_q <= MapHeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMapWidth:  map_width_q  <= cfg_data_i;
        CfgMapHeight: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = (map_width_q > coord_t'(MaxWidth)) ? coord_t'(MaxWidth) : map_width_q;
  assign height_eff = (map_height_q > coord_t'(MaxHeight)) ? coord_t'(MaxHeight)
                                                            : map_height_q;

  dgat_row_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dgat_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .width_i        (width_eff),
    .height_i       (height_eff),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .result_o       (result),
    .result_valid_o (result_valid_o)
  );

  assign in_range_o      = result.in_range;
  assign mask_o          = result.mask;
  assign tile_kind_o     = result.kind;
  assign quarter_turns_o = result.turns;

endmodule

[rtl/dgat_row_mem.sv]
// occupancy bitmap stored as one word per row with per-row valid bits
module dgat_row_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dgat_pkg::mem_req_t   req_i,
  output dgat_pkg::row_word_t  rdata_o
);
  import dgat_pkg::*;

  logic [MaxHeight-1:0] row_valid_q;
  row_word_t            mem_q [MaxHeight];
  row_word_t            rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (req_i.wr_en) begin
      row_valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= row_valid_q[req_i.rd_addr] ? mem_q[req_i.rd_addr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dgat_pick.sv]
// picks the left and right cells around a visual column from one row word
module dgat_pick (
  input  dgat_pkg::row_word_t rdata_i,
  input  dgat_pkg::coord_t    col_i,
  input  dgat_pkg::coord_t    width_i,
  output logic [1:0]          pair_o
);
  import dgat_pkg::*;

  col_idx_t right_idx;
  col_idx_t left_idx;
  logic     left_ok;
  logic     right_ok;

  assign right_idx = col_i[ColIdxW-1:0];
  assign left_idx  = right_idx - col_idx_t'(1);
  assign left_ok   = (col_i != '0);
  assign right_ok  = (col_i < width_i);

  assign pair_o = {rdata_i[left_idx] & left_ok, rdata_i[right_idx] & right_ok};

endmodule

[rtl/dgat_ctrl.sv]
// sequencer for set, clear and query items over the row memory
module dgat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action_i,
  input  dgat_pkg::coord_t    col_i,
  input  dgat_pkg::coord_t    row_i,
  input  dgat_pkg::coord_t    width_i,
  input  dgat_pkg::coord_t    height_i,
  output dgat_pkg::mem_req_t  mem_req_o,
  input  dgat_pkg::row_word_t mem_rdata_i,
  output dgat_pkg::result_t   result_o,
  output logic                result_valid_o
);
  import dgat_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRdA  = 4'b0010,
    StRdB  = 4'b0100,
    StRdC  = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] act_q, act_d;
  coord_t     col_q, col_d;
  coord_t     row_q, row_d;
  logic [1:0] top_q, top_d;
  result_t    res_q, res_d;
  logic       res_valid_q, res_valid_d;

  logic       pair;
  logic [1:0] pick_pair;
  logic       top_ok;
  logic       bot_ok;
  logic [3:0] query_mask;
  row_word_t  wr_word;

  dgat_pick u_pick (
    .rdata_i (mem_rdata_i),
    .col_i   (col_q),
    .width_i (width_i),
    .pair_o  (pick_pair)
  );

  assign pair       = (act_q == ActQuery);
  assign top_ok     = (row_q != '0);
  assign bot_ok     = (row_q < height_i);
  assign query_mask = {top_q, pick_pair & {2{bot_ok}}};

  always_comb begin
    wr_word = mem_rdata_i;
    wr_word[col_q[ColIdxW-1:0]] = (act_q == ActSet);
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    col_d       = col_q;
    row_d       = row_q;
    top_d       = top_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_req_o   = '0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          act_d = action_i;
          col_d = col_i;
          row_d = row_i;
          res_d = '0;
          case (action_i) inside
            ActSet, ActClear: begin
              if (col_i < width_i && row_i < height_i) begin
                state_d = StRdA;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            ActQuery: begin
              if (col_i <= width_i && row_i <= height_i) begin
                state_d = StRdA;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      StRdA: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = pair ? row_q[RowIdxW-1:0] - row_idx_t'(1)
                                 : row_q[RowIdxW-1:0];
        state_d = StRdB;
      end
      StRdB: begin
        if (pair) begin
          top_d             = pick_pair & {2{top_ok}};
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = row_q[RowIdxW-1:0];
          state_d           = StRdC;
        end else begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = row_q[RowIdxW-1:0];
          mem_req_o.wr_data = wr_word;
          res_d             = '0;
          res_d.in_range    = 1'b1;
          res_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      StRdC: begin
        res_d.in_range = 1'b1;
        res_d.mask     = query_mask;
        res_d.kind     = kind_of_mask(query_mask);
        res_d.turns    = turns_of_mask(query_mask);
        res_valid_d    = 1'b1;
        state_d        = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    col_q <= col_d;
    row_q <= row_d;
    top_q <= top_d;
    res_q <= res_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

[rtl/dgat_checker.sv]
// port-level checks for the dual grid autotile block and their binding
`include "dual_grid_autotile_mask_macros.svh"

module dgat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       in_range_o,
  input logic [3:0] mask_o,
  input logic [2:0] tile_kind_o,
  input logic [1:0] quarter_turns_o
);
  import dgat_pkg::*;

  `DGAT_ASSERT_NEXT(a_accept_acts, clk_i, rst_ni, start && !busy, busy || result_valid_o, "accepted item neither started work nor gave a result")
  `DGAT_ASSERT(a_done_on_fall, clk_i, rst_ni, $fell(busy) |-> result_valid_o, "work ended without a result")
  `DGAT_ASSERT(a_miss_zero, clk_i, rst_ni, result_valid_o && !in_range_o |-> mask_o == 4'd0 && tile_kind_o == KindEmpty && quarter_turns_o == 2'd0, "rejected item has nonzero fields")
  `DGAT_ASSERT(a_full_mask, clk_i, rst_ni, result_valid_o && tile_kind_o == KindFull |-> mask_o == 4'hF, "full tile without all four cells")

endmodule

bind dual_grid_autotile_mask dgat_checker u_dgat_checker (.*);
